@@ rtl/cnp_pkg.sv @@
// package for the capsule nearest point block
// widths, configuration register indexes and the side band types of the pipeline
// no dependencies
package cnp_pkg;

    localparam int CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_END_X,
        CFG_END_Y,
        CFG_RADIUS
    } t_cfg_idx;

    // projection divider: t * |d| / |d|^2
    localparam int PRJ_NW = 97;
    localparam int PRJ_DW = 65;
    localparam int PRJ_QW = 32;

    // square root of the squared offset length
    localparam int SQ_VW = 68;

    // scaling divider: r * |v| / isqrt(|v|^2)
    localparam int SC_NW = 65;
    localparam int SC_DW = 34;
    localparam int SC_QW = 31;

    typedef struct packed {
        logic signed [32:0] px;
        logic signed [32:0] py;
        logic signed [32:0] qx;
        logic signed [32:0] qy;
        logic signed [31:0] px0;
        logic signed [31:0] py0;
        logic [64:0]        pp2;
        logic [64:0]        qq2;
        logic [61:0]        r2;
        logic               dzero;
        logic               bfr;
        logic               pst;
        logic               capin;
    } t_prj_side;

    typedef struct packed {
        logic [33:0]        vmx;
        logic [33:0]        vmy;
        logic               vnx;
        logic               vny;
        logic signed [34:0] bx;
        logic signed [34:0] by;
        logic               in_cap;
        logic signed [31:0] px0;
        logic signed [31:0] py0;
    } t_sq_side;

    typedef struct packed {
        logic signed [34:0] bx;
        logic signed [34:0] by;
        logic               in_cap;
        logic               nzero;
        logic signed [31:0] px0;
        logic signed [31:0] py0;
    } t_sc_side;

endpackage

@@ rtl/cnp_div.sv @@
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage
// rounds half away from zero; carries a side band alongside; no dependencies
module cnp_div #(
    parameter int NW = 97,
    parameter int DW = 65,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NW-1:0]        i_num_a,
    input  logic [NW-1:0]        i_num_b,
    input  logic                 i_neg_a,
    input  logic                 i_neg_b,
    input  logic [DW-1:0]        i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [QW+1:0] o_quo_a,
    output logic signed [QW+1:0] o_quo_b,
    output logic [SW-1:0]        o_side
);

    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                             input logic [DW-1:0] den);
        logic [DW:0] sh;
        logic [DW:0] df;
        begin
            sh = {rem, nb};
            df = sh - {1'b0, den};
            if (sh >= {1'b0, den}) begin
                div_step = {1'b1, df[DW-1:0]};
            end else begin
                div_step = {1'b0, sh[DW-1:0]};
            end
        end
    endfunction

    logic          r_vld   [0:QW];
    logic [DW-1:0] r_den   [0:QW];
    logic [DW-1:0] r_rem_a [0:QW];
    logic [DW-1:0] r_rem_b [0:QW];
    logic [QW-1:0] r_low_a [0:QW];
    logic [QW-1:0] r_low_b [0:QW];
    logic [QW-1:0] r_quo_a [0:QW];
    logic [QW-1:0] r_quo_b [0:QW];
    logic          r_neg_a [0:QW];
    logic          r_neg_b [0:QW];
    logic [SW-1:0] r_side  [0:QW];
    logic [DW:0]   w_sa    [0:QW-1];
    logic [DW:0]   w_sb    [0:QW-1];

    logic                 r_ov;
    logic signed [QW+1:0] r_oqa;
    logic signed [QW+1:0] r_oqb;
    logic [SW-1:0]        r_oside;

    logic          w_rnd_a;
    logic          w_rnd_b;
    logic [QW:0]   w_qra;
    logic [QW:0]   w_qrb;

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_sa[k] = div_step(r_rem_a[k], r_low_a[k][QW-1], r_den[k]);
            w_sb[k] = div_step(r_rem_b[k], r_low_b[k][QW-1], r_den[k]);
        end
    end

    assign w_rnd_a = {r_rem_a[QW], 1'b0} >= {1'b0, r_den[QW]};
    assign w_rnd_b = {r_rem_b[QW], 1'b0} >= {1'b0, r_den[QW]};
    assign w_qra   = {1'b0, r_quo_a[QW]} + (QW+1)'(w_rnd_a);
    assign w_qrb   = {1'b0, r_quo_b[QW]} + (QW+1)'(w_rnd_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < QW; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_ov <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]   <= i_den;
            r_rem_a[0] <= DW'(i_num_a >> QW);
            r_rem_b[0] <= DW'(i_num_b >> QW);
            r_low_a[0] <= i_num_a[QW-1:0];
            r_low_b[0] <= i_num_b[QW-1:0];
            r_quo_a[0] <= '0;
            r_quo_b[0] <= '0;
            r_neg_a[0] <= i_neg_a;
            r_neg_b[0] <= i_neg_b;
            r_side[0]  <= i_side;
            for (int k = 0; k < QW; k++) begin
                r_den[k+1]   <= r_den[k];
                r_rem_a[k+1] <= w_sa[k][DW-1:0];
                r_rem_b[k+1] <= w_sb[k][DW-1:0];
                r_low_a[k+1] <= r_low_a[k] << 1;
                r_low_b[k+1] <= r_low_b[k] << 1;
                r_quo_a[k+1] <= {r_quo_a[k][QW-2:0], w_sa[k][DW]};
                r_quo_b[k+1] <= {r_quo_b[k][QW-2:0], w_sb[k][DW]};
                r_neg_a[k+1] <= r_neg_a[k];
                r_neg_b[k+1] <= r_neg_b[k];
                r_side[k+1]  <= r_side[k];
            end
            r_oqa   <= r_neg_a[QW] ? -$signed({1'b0, w_qra}) : $signed({1'b0, w_qra});
            r_oqb   <= r_neg_b[QW] ? -$signed({1'b0, w_qrb}) : $signed({1'b0, w_qrb});
            r_oside <= r_side[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_quo_a = r_oqa;
    assign o_quo_b = r_oqb;
    assign o_side  = r_oside;

endmodule

@@ rtl/cnp_sqrt.sv @@
// pipelined floor square root, one root bit a stage
// carries a side band alongside; no dependencies
module cnp_sqrt #(
    parameter int VW = 68,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [VW-1:0]     i_val,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [VW/2-1:0]   o_root,
    output logic [SW-1:0]     o_side
);

    localparam int HW = VW / 2;

    logic          r_vld  [0:HW];
    logic [VW-1:0] r_val  [0:HW];
    logic [HW:0]   r_rem  [0:HW];
    logic [HW-1:0] r_root [0:HW];
    logic [SW-1:0] r_side [0:HW];
    logic [HW+2:0] w_sh   [0:HW-1];
    logic [HW+2:0] w_tr   [0:HW-1];
    logic [HW+2:0] w_df   [0:HW-1];
    logic          w_ge   [0:HW-1];

    always_comb begin
        for (int k = 0; k < HW; k++) begin
            w_sh[k] = {r_rem[k], r_val[k][VW-1:VW-2]};
            w_tr[k] = {1'b0, r_root[k], 2'b01};
            w_df[k] = w_sh[k] - w_tr[k];
            w_ge[k] = w_sh[k] >= w_tr[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= HW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < HW; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0]  <= i_val;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int k = 0; k < HW; k++) begin
                r_val[k+1]  <= r_val[k] << 2;
                r_rem[k+1]  <= w_ge[k] ? w_df[k][HW:0] : w_sh[k][HW:0];
                r_root[k+1] <= {r_root[k][HW-2:0], w_ge[k]};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[HW];
    assign o_root  = r_root[HW];
    assign o_side  = r_side[HW];

endmodule

@@ rtl/capsule_nearest_point_2d.sv @@
// top level of the capsule nearest point block: configuration, products and region logic
// depends on cnp_pkg, cnp_div and cnp_sqrt
//
// Nearest point on a 2D capsule in signed Q16.16.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; start x/y,
// end x/y and radius, written while no item is in flight. o_cfg_ready is always high.
// Input: i_in_valid/o_in_ready with i_point_x, i_point_y. Output: o_out_valid/i_out_ready
// with o_near_x, o_near_y (saturated) and o_inside_res.
// From acceptance to o_out_valid an item passes five product stages, the
// 34-stage projection divider, three offset stages, the 35-stage square root, one
// numerator stage, the 33-stage scaling divider and the output register.
// Throughput is one item per cycle while the receiver does not stall; every stage holds one item.
// The whole pipeline advances together: it moves when the output register is empty
// or its item is taken, and freezes while the receiver stalls with a result waiting.
// New items enter the first stage when the pipeline advances; empty stages move along and are not squeezed out.
// Reset clears the configuration registers to zero and all valid bits.
module capsule_nearest_point_2d
    import cnp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_near_x,
    output logic signed [31:0]  o_near_y,
    output logic                o_inside_res
);

    localparam int PRJ_SW = $bits(t_prj_side);
    localparam int SQ_SW  = $bits(t_sq_side);
    localparam int SC_SW  = $bits(t_sc_side);
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    function automatic logic [63:0] sq33(input logic signed [32:0] a);
        logic signed [65:0] m;
        begin
            m = 66'(a) * 66'(a);
            sq33 = m[63:0];
        end
    endfunction

    function automatic logic [65:0] sq35(input logic signed [34:0] a);
        logic signed [69:0] m;
        begin
            m = 70'(a) * 70'(a);
            sq35 = m[65:0];
        end
    endfunction

    function automatic logic [33:0] mag35(input logic signed [34:0] v);
        logic signed [34:0] m;
        begin
            m = -v;
            mag35 = v[34] ? m[33:0] : v[33:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        begin
            if (v > SAT_MAX) begin
                sat32 = 32'sh7fffffff;
            end else if (v < SAT_MIN) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

    logic signed [31:0] r_sx, r_sy, r_ex, r_ey;
    logic [30:0]        r_rad;
    logic               w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_ex  <= '0;
            r_ey  <= '0;
            r_rad <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_X: r_sx  <= $signed(i_cfg_data);
                CFG_START_Y: r_sy  <= $signed(i_cfg_data);
                CFG_END_X:   r_ex  <= $signed(i_cfg_data);
                CFG_END_Y:   r_ey  <= $signed(i_cfg_data);
                CFG_RADIUS:  r_rad <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_g_v, r_h_v, r_i_v, r_j_v, r_k_v;

    assign w_en       = !r_k_v || i_out_ready;
    assign o_in_ready = w_en;

    // stage a: offsets from the axis ends
    logic signed [32:0] r_a_px, r_a_py, r_a_qx, r_a_qy, r_a_dx, r_a_dy;
    logic signed [31:0] r_a_px0, r_a_py0;
    // stage b: products
    logic signed [65:0] r_b_pdx, r_b_pdy;
    logic [63:0]        r_b_px2, r_b_py2, r_b_qx2, r_b_qy2, r_b_dx2, r_b_dy2;
    logic [61:0]        r_b_r2;
    logic signed [32:0] r_b_px, r_b_py, r_b_qx, r_b_qy, r_b_dx, r_b_dy;
    logic signed [31:0] r_b_px0, r_b_py0;
    // stage c: sums
    logic signed [66:0] r_c_t;
    logic [64:0]        r_c_l2, r_c_pp2, r_c_qq2;
    logic [61:0]        r_c_r2;
    logic signed [32:0] r_c_px, r_c_py, r_c_qx, r_c_qy, r_c_dx, r_c_dy;
    logic signed [31:0] r_c_px0, r_c_py0;
    // stage d: regions
    logic [64:0]        r_d_tc, r_d_l2;
    logic [31:0]        r_d_mx, r_d_my;
    logic               r_d_nx, r_d_ny;
    t_prj_side          r_d_side;
    logic signed [32:0] w_c_ndx, w_c_ndy;
    logic               w_c_bfr, w_c_pst;
    // stage e: projection partial products
    logic [64:0]        r_e_xh, r_e_yh, r_e_l2;
    logic [63:0]        r_e_xl, r_e_yl;
    logic               r_e_nx, r_e_ny;
    t_prj_side          r_e_side;
    logic [PRJ_NW-1:0]  w_e_numx, w_e_numy;
    // projection divider output
    logic               w_g_in_v;
    logic signed [PRJ_QW+1:0] w_fx, w_fy;
    t_prj_side          w_g_side;
    // stage g and h: perpendicular offset
    logic signed [34:0] r_g_ox, r_g_oy;
    logic signed [33:0] r_g_fx, r_g_fy;
    t_prj_side          r_g_side;
    logic [65:0]        r_h_ox2, r_h_oy2;
    logic signed [34:0] r_h_ox, r_h_oy;
    logic signed [33:0] r_h_fx, r_h_fy;
    t_prj_side          r_h_side;
    // stage i: selection
    logic [66:0]        w_h_so2;
    logic               w_h_inside;
    logic signed [34:0] w_h_vx, w_h_vy;
    logic [SQ_VW-1:0]   n_i_vsq;
    t_sq_side           n_i_side;
    logic [SQ_VW-1:0]   r_i_vsq;
    t_sq_side           r_i_side;
    // square root output
    logic               w_j_in_v;
    logic [SQ_VW/2-1:0] w_n;
    t_sq_side           w_j_side;
    // stage j: scaling numerators
    logic [SC_NW-1:0]   r_j_nx, r_j_ny;
    logic               r_j_negx, r_j_negy;
    logic [SC_DW-1:0]   r_j_n;
    t_sc_side           r_j_side;
    // scaling divider output
    logic               w_k_in_v;
    logic signed [SC_QW+1:0] w_sx, w_sy;
    t_sc_side           w_k_side;
    logic signed [SC_QW+1:0] w_sxe, w_sye;
    // stage k: output register
    logic signed [31:0] r_k_x, r_k_y;
    logic               r_k_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_g_v <= w_g_in_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= w_j_in_v;
            r_k_v <= w_k_in_v;
        end
    end

    assign w_c_ndx = -r_c_dx;
    assign w_c_ndy = -r_c_dy;
    assign w_c_bfr = r_c_t[66];
    assign w_c_pst = r_c_t > $signed({2'b00, r_c_l2});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_px  <= 33'(i_point_x) - 33'(r_sx);
            r_a_py  <= 33'(i_point_y) - 33'(r_sy);
            r_a_qx  <= 33'(i_point_x) - 33'(r_ex);
            r_a_qy  <= 33'(i_point_y) - 33'(r_ey);
            r_a_dx  <= 33'(r_ex) - 33'(r_sx);
            r_a_dy  <= 33'(r_ey) - 33'(r_sy);
            r_a_px0 <= i_point_x;
            r_a_py0 <= i_point_y;

            r_b_pdx <= 66'(r_a_px) * 66'(r_a_dx);
            r_b_pdy <= 66'(r_a_py) * 66'(r_a_dy);
            r_b_px2 <= sq33(r_a_px);
            r_b_py2 <= sq33(r_a_py);
            r_b_qx2 <= sq33(r_a_qx);
            r_b_qy2 <= sq33(r_a_qy);
            r_b_dx2 <= sq33(r_a_dx);
            r_b_dy2 <= sq33(r_a_dy);
            r_b_r2  <= 62'(r_rad) * 62'(r_rad);
            r_b_px  <= r_a_px;
            r_b_py  <= r_a_py;
            r_b_qx  <= r_a_qx;
            r_b_qy  <= r_a_qy;
            r_b_dx  <= r_a_dx;
            r_b_dy  <= r_a_dy;
            r_b_px0 <= r_a_px0;
            r_b_py0 <= r_a_py0;

            r_c_t   <= 67'(r_b_pdx) + 67'(r_b_pdy);
            r_c_l2  <= 65'(r_b_dx2) + 65'(r_b_dy2);
            r_c_pp2 <= 65'(r_b_px2) + 65'(r_b_py2);
            r_c_qq2 <= 65'(r_b_qx2) + 65'(r_b_qy2);
            r_c_r2  <= r_b_r2;
            r_c_px  <= r_b_px;
            r_c_py  <= r_b_py;
            r_c_qx  <= r_b_qx;
            r_c_qy  <= r_b_qy;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_px0 <= r_b_px0;
            r_c_py0 <= r_b_py0;

            r_d_tc         <= (w_c_bfr || w_c_pst) ? '0 : r_c_t[64:0];
            r_d_l2         <= r_c_l2;
            r_d_mx         <= r_c_dx[32] ? w_c_ndx[31:0] : r_c_dx[31:0];
            r_d_my         <= r_c_dy[32] ? w_c_ndy[31:0] : r_c_dy[31:0];
            r_d_nx         <= r_c_dx[32];
            r_d_ny         <= r_c_dy[32];
            r_d_side.px    <= r_c_px;
            r_d_side.py    <= r_c_py;
            r_d_side.qx    <= r_c_qx;
            r_d_side.qy    <= r_c_qy;
            r_d_side.px0   <= r_c_px0;
            r_d_side.py0   <= r_c_py0;
            r_d_side.pp2   <= r_c_pp2;
            r_d_side.qq2   <= r_c_qq2;
            r_d_side.r2    <= r_c_r2;
            r_d_side.dzero <= r_c_l2 == '0;
            r_d_side.bfr   <= w_c_bfr;
            r_d_side.pst   <= w_c_pst;
            r_d_side.capin <= (r_c_pp2 < 65'(r_c_r2)) || (r_c_qq2 < 65'(r_c_r2));

            r_e_xh   <= 65'(r_d_tc[64:32]) * 65'(r_d_mx);
            r_e_yh   <= 65'(r_d_tc[64:32]) * 65'(r_d_my);
            r_e_xl   <= 64'(r_d_tc[31:0]) * 64'(r_d_mx);
            r_e_yl   <= 64'(r_d_tc[31:0]) * 64'(r_d_my);
            r_e_nx   <= r_d_nx;
            r_e_ny   <= r_d_ny;
            r_e_l2   <= r_d_l2;
            r_e_side <= r_d_side;
        end
    end

    assign w_e_numx = {r_e_xh, 32'd0} + PRJ_NW'(r_e_xl);
    assign w_e_numy = {r_e_yh, 32'd0} + PRJ_NW'(r_e_yl);

    cnp_div #(
        .NW (PRJ_NW),
        .DW (PRJ_DW),
        .QW (PRJ_QW),
        .SW (PRJ_SW)
    ) u_prj_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_v),
        .i_num_a (w_e_numx),
        .i_num_b (w_e_numy),
        .i_neg_a (r_e_nx),
        .i_neg_b (r_e_ny),
        .i_den   (r_e_l2),
        .i_side  (r_e_side),
        .o_valid (w_g_in_v),
        .o_quo_a (w_fx),
        .o_quo_b (w_fy),
        .o_side  (w_g_side)
    );

    // region selection
    assign w_h_so2    = 67'(r_h_ox2) + 67'(r_h_oy2);
    assign w_h_inside = r_h_side.capin || (!r_h_side.dzero && !r_h_side.bfr &&
                        !r_h_side.pst && (w_h_so2 <= 67'(r_h_side.r2)));

    always_comb begin
        n_i_side.in_cap = w_h_inside;
        n_i_side.px0    = r_h_side.px0;
        n_i_side.py0    = r_h_side.py0;
        priority if (r_h_side.dzero || r_h_side.bfr) begin
            w_h_vx      = 35'(r_h_side.px);
            w_h_vy      = 35'(r_h_side.py);
            n_i_vsq     = SQ_VW'(r_h_side.pp2);
            n_i_side.bx = 35'(r_sx);
            n_i_side.by = 35'(r_sy);
        end else if (r_h_side.pst) begin
            w_h_vx      = 35'(r_h_side.qx);
            w_h_vy      = 35'(r_h_side.qy);
            n_i_vsq     = SQ_VW'(r_h_side.qq2);
            n_i_side.bx = 35'(r_ex);
            n_i_side.by = 35'(r_ey);
        end else begin
            w_h_vx      = r_h_ox;
            w_h_vy      = r_h_oy;
            n_i_vsq     = SQ_VW'(w_h_so2);
            n_i_side.bx = 35'(r_sx) + 35'(r_h_fx);
            n_i_side.by = 35'(r_sy) + 35'(r_h_fy);
        end
        n_i_side.vmx = mag35(w_h_vx);
        n_i_side.vmy = mag35(w_h_vy);
        n_i_side.vnx = w_h_vx[34];
        n_i_side.vny = w_h_vy[34];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_ox   <= 35'(w_g_side.px) - 35'(w_fx);
            r_g_oy   <= 35'(w_g_side.py) - 35'(w_fy);
            r_g_fx   <= w_fx;
            r_g_fy   <= w_fy;
            r_g_side <= w_g_side;

            r_h_ox2  <= sq35(r_g_ox);
            r_h_oy2  <= sq35(r_g_oy);
            r_h_ox   <= r_g_ox;
            r_h_oy   <= r_g_oy;
            r_h_fx   <= r_g_fx;
            r_h_fy   <= r_g_fy;
            r_h_side <= r_g_side;

            r_i_vsq  <= n_i_vsq;
            r_i_side <= n_i_side;
        end
    end

    cnp_sqrt #(
        .VW (SQ_VW),
        .SW (SQ_SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_i_v),
        .i_val   (r_i_vsq),
        .i_side  (r_i_side),
        .o_valid (w_j_in_v),
        .o_root  (w_n),
        .o_side  (w_j_side)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_nx          <= SC_NW'(r_rad) * SC_NW'(w_j_side.vmx);
            r_j_ny          <= SC_NW'(r_rad) * SC_NW'(w_j_side.vmy);
            r_j_negx        <= w_j_side.vnx;
            r_j_negy        <= w_j_side.vny;
            r_j_n           <= w_n;
            r_j_side.bx     <= w_j_side.bx;
            r_j_side.by     <= w_j_side.by;
            r_j_side.in_cap <= w_j_side.in_cap;
            r_j_side.nzero  <= w_n == '0;
            r_j_side.px0    <= w_j_side.px0;
            r_j_side.py0    <= w_j_side.py0;
        end
    end

    cnp_div #(
        .NW (SC_NW),
        .DW (SC_DW),
        .QW (SC_QW),
        .SW (SC_SW)
    ) u_sc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_j_v),
        .i_num_a (r_j_nx),
        .i_num_b (r_j_ny),
        .i_neg_a (r_j_negx),
        .i_neg_b (r_j_negy),
        .i_den   (r_j_n),
        .i_side  (r_j_side),
        .o_valid (w_k_in_v),
        .o_quo_a (w_sx),
        .o_quo_b (w_sy),
        .o_side  (w_k_side)
    );

    assign w_sxe = w_k_side.nzero ? '0 : w_sx;
    assign w_sye = w_k_side.nzero ? '0 : w_sy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_in <= w_k_side.in_cap;
            r_k_x  <= w_k_side.in_cap ? w_k_side.px0 :
                      sat32(36'(w_k_side.bx) + 36'(w_sxe));
            r_k_y  <= w_k_side.in_cap ? w_k_side.py0 :
                      sat32(36'(w_k_side.by) + 36'(w_sye));
        end
    end

    assign o_out_valid  = r_k_v;
    assign o_near_x     = r_k_x;
    assign o_near_y     = r_k_y;
    assign o_inside_res = r_k_in;

    // an accepted item enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_a_v)
        else $error("accepted item missing from first stage");

    // a frozen pipeline keeps its first and last stages
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> (r_a_v == $past(r_a_v)) && (r_k_v == $past(r_k_v)))
        else $error("pipeline moved while stalled");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
